// ===== rtl/rsd_pkg.sv =====
package rsd_pkg;

  localparam int unsigned SCREEN_W  = 240;
  localparam int unsigned SCREEN_H  = 160;
  localparam int unsigned MIN_WIDTH = 8;

  localparam int unsigned WORD_W  = 16;
  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned COLOR_W = 15;
  localparam int unsigned CFG_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_DATA_W = 40;

  localparam int unsigned OPAQUE_BIT = 15;

  localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(32);
  localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(32);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ORIGIN_X      = 2'd0,
    REG_ORIGIN_Y      = 2'd1,
    REG_SPRITE_WIDTH  = 2'd2,
    REG_SPRITE_HEIGHT = 2'd3
  } reg_idx_t;

  typedef enum logic [1:0] {
    PHASE_HEADER = 2'd0,
    PHASE_FIRST  = 2'd1,
    PHASE_SECOND = 2'd2,
    PHASE_UNUSED = 2'd3
  } phase_t;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic hdr_phase;
    logic run_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ===== rtl/rsd_ctrl.sv =====
module rsd_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  rsd_pkg::dp_sts_t sts,
  output rsd_pkg::dp_cmd_t cmd
);

  rsd_pkg::state_t state_r;
  rsd_pkg::state_t state_nxt;
  logic            accept;

  assign accept = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rsd_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsd_pkg::ST_IDLE: begin
        if (accept && !sts.hdr_phase) begin
          state_nxt = rsd_pkg::ST_RUN;
        end
      end
      rsd_pkg::ST_RUN: begin
        if (sts.run_done) begin
          state_nxt = rsd_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rsd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state_r)
      rsd_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      rsd_pkg::ST_RUN: begin
        cmd.finish = sts.run_done;
        cmd.step   = !sts.run_done && sts.out_free;
      end
      default: ;
    endcase
  end

endmodule

// ===== rtl/rsd_datapath.sv =====
module rsd_datapath (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [rsd_pkg::WORD_W-1:0]         in_word,
  input  logic                               cfg_valid,
  input  logic [rsd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rsd_pkg::CFG_W-1:0]          cfg_data,
  input  rsd_pkg::dp_cmd_t                   cmd,
  output rsd_pkg::dp_sts_t                   sts,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [rsd_pkg::OUT_DATA_W-1:0]     out_tdata,
  output logic                               out_tlast
);

  localparam int unsigned CW = rsd_pkg::CNT_W;
  localparam int unsigned AW = rsd_pkg::ADDR_W;

  logic [rsd_pkg::CFG_W-1:0] origin_x_r, origin_y_r, width_r, height_r;

  rsd_pkg::phase_t phase_r;
  logic [CW-1:0]   first_cnt_r, second_cnt_r;
  logic [CW-1:0]   col_r, row_r;
  logic [CW-1:0]   cnt_r;
  logic [rsd_pkg::COLOR_W-1:0] color_r;
  logic            opaque_r;
  logic            grp_end_r;

  logic                        out_valid_r;
  logic [AW-1:0]               seg_addr_r;
  logic [CW-1:0]               seg_len_r;
  logic [rsd_pkg::COLOR_W-1:0] seg_color_r;
  logic                        seg_last_r;

  logic [CW-1:0] w_eff;
  logic          col_over;
  logic [CW-1:0] room;
  logic [CW-1:0] seg;
  logic [CW:0]   col_sum;
  logic [CW-1:0] cnt_nxt;
  logic [CW-1:0] col_nxt;
  logic [CW:0]   row_inc;
  logic [CW-1:0] row_nxt;
  logic          emit;
  logic          seg_last;
  logic [AW-1:0] srow;
  logic [AW-1:0] scol;
  logic [AW-1:0] addr;

  always_comb begin
    w_eff = (width_r < CW'(rsd_pkg::MIN_WIDTH)) ? CW'(rsd_pkg::MIN_WIDTH) : width_r;
    col_over = (col_r >= w_eff);
    room = w_eff - col_r;
    seg  = (cnt_r < room) ? cnt_r : room;
    col_sum = {1'b0, col_r} + {1'b0, seg};
    row_inc = {1'b0, row_r} + (CW+1)'(1);
    if (col_over) begin
      cnt_nxt = cnt_r;
      col_nxt = '0;
      row_nxt = row_inc[CW-1:0];
      emit    = 1'b0;
    end else begin
      cnt_nxt = cnt_r - seg;
      emit    = opaque_r;
      if (col_sum >= {1'b0, w_eff}) begin
        col_nxt = '0;
        row_nxt = row_inc[CW-1:0];
      end else begin
        col_nxt = col_sum[CW-1:0];
        row_nxt = row_r;
      end
    end
    seg_last = (cnt_nxt == '0) || (row_nxt >= height_r);
    srow = AW'(origin_y_r) + AW'(height_r) - AW'(1) - AW'(row_r);
    scol = AW'(origin_x_r) + AW'(col_r);
    addr = AW'(srow * AW'(rsd_pkg::SCREEN_W)) + scol;
  end

  assign sts.hdr_phase = (phase_r != rsd_pkg::PHASE_FIRST) &&
                         (phase_r != rsd_pkg::PHASE_SECOND);
  assign sts.run_done  = (cnt_r == '0) || (row_r >= height_r);
  assign sts.out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      width_r    <= rsd_pkg::WIDTH_RESET;
      height_r   <= rsd_pkg::HEIGHT_RESET;
    end else if (cfg_valid) begin
      unique case (rsd_pkg::reg_idx_t'(cfg_index))
        rsd_pkg::REG_ORIGIN_X:      origin_x_r <= cfg_data;
        rsd_pkg::REG_ORIGIN_Y:      origin_y_r <= cfg_data;
        rsd_pkg::REG_SPRITE_WIDTH:  width_r    <= cfg_data;
        rsd_pkg::REG_SPRITE_HEIGHT: height_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= rsd_pkg::PHASE_HEADER;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      col_r        <= '0;
      row_r        <= '0;
      cnt_r        <= '0;
      grp_end_r    <= 1'b0;
    end else begin
      if (cmd.load) begin
        unique case (phase_r)
          rsd_pkg::PHASE_FIRST: begin
            cnt_r     <= first_cnt_r;
            grp_end_r <= 1'b0;
            phase_r   <= rsd_pkg::PHASE_SECOND;
          end
          rsd_pkg::PHASE_SECOND: begin
            cnt_r     <= second_cnt_r;
            grp_end_r <= 1'b1;
            phase_r   <= rsd_pkg::PHASE_HEADER;
          end
          default: begin
            first_cnt_r  <= in_word[2*CW-1:CW];
            second_cnt_r <= in_word[CW-1:0];
            phase_r      <= rsd_pkg::PHASE_FIRST;
          end
        endcase
      end
      if (cmd.step) begin
        cnt_r <= cnt_nxt;
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (cmd.finish && grp_end_r && (row_r >= height_r)) begin
        col_r <= '0;
        row_r <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      color_r  <= in_word[rsd_pkg::COLOR_W-1:0];
      opaque_r <= in_word[rsd_pkg::OPAQUE_BIT];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.step && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && emit) begin
      seg_addr_r  <= addr;
      seg_len_r   <= seg;
      seg_color_r <= color_r;
      seg_last_r  <= seg_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, seg_color_r, seg_len_r, seg_addr_r};
  assign out_tlast  = seg_last_r;

endmodule

// ===== rtl/rle_sprite_run_decoder.sv =====
// Run-length sprite decoder. Takes 16-bit coded words (header, colour, colour) and
// emits framebuffer fill segments, each clipped to one sprite row, rows placed bottom-up
// from the configured origin. A header word is taken while idle. A colour word is loaded,
// then the segment sequencer takes one step per row touched by the run (plus one if the
// width was lowered mid-sprite), each step waiting while the result side stalls a
// segment in the output register, and a closing step returns to idle. Configuration
// is taken at any time; write it only while the block is idle.
module rle_sprite_run_decoder (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [rsd_pkg::WORD_W-1:0]           in_tdata,   // [15:0] data_word
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [15:0] segment_address, [23:16] segment_length, [38:24] fill_color, [39] zero
  output logic [rsd_pkg::OUT_DATA_W-1:0]       out_tdata,
  output logic                                 out_tlast,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [rsd_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [rsd_pkg::CFG_W-1:0]            cfg_data
);

  rsd_pkg::dp_cmd_t cmd;
  rsd_pkg::dp_sts_t sts;

  assign cfg_ready = 1'b1;

  rsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rsd_datapath u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

// ===== tb/rle_sprite_run_decoder_test.sv =====
`timescale 1ns / 1ps

module rle_sprite_run_decoder_test;
  import rsd_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam int unsigned RANDOM_WORDS = 140;
  localparam int unsigned MAX_SEGMENTS = 33;

  typedef struct packed {
    logic [ADDR_W-1:0]  addr;
    logic [CNT_W-1:0]   len;
    logic [COLOR_W-1:0] color;
    logic               last;
  } segment_t;

  typedef enum bit {ROW_WORD, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t         kind;
    reg_idx_t          idx;
    logic [WORD_W-1:0] value;
    bit                typed;
    segment_t          want;
  } script_row_t;

  localparam int SCRIPT_LEN = 32;
  localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
    '{ROW_WORD, REG_ORIGIN_X,      16'h0203, 1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'h801F, 1'b1, '{16'h1D10, 8'd2, 15'h001F, 1'b1}},
    '{ROW_WORD, REG_ORIGIN_X,      16'h0000, 1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'hFF00, 1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'hFFFF, 1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'h8000, 1'b0, '0},
    '{ROW_CFG,  REG_SPRITE_HEIGHT, 16'd0,    1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'h0505, 1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'h8123, 1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'h8456, 1'b0, '0},
    '{ROW_CFG,  REG_SPRITE_HEIGHT, 16'd1,    1'b0, '0},
    '{ROW_CFG,  REG_SPRITE_WIDTH,  16'd3,    1'b0, '0},
    '{ROW_CFG,  REG_ORIGIN_X,      16'd255,  1'b0, '0},
    '{ROW_CFG,  REG_ORIGIN_Y,      16'd255,  1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'h0A01, 1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'hFFFF, 1'b1, '{16'hF00F, 8'd8, 15'h7FFF, 1'b1}},
    '{ROW_WORD, REG_ORIGIN_X,      16'h8001, 1'b0, '0},
    '{ROW_CFG,  REG_SPRITE_HEIGHT, 16'd255,  1'b0, '0},
    '{ROW_CFG,  REG_ORIGIN_X,      16'd0,    1'b0, '0},
    '{ROW_CFG,  REG_SPRITE_WIDTH,  16'd240,  1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'h0100, 1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'h8000, 1'b1, '{16'hDD30, 8'd1, 15'h0000, 1'b1}},
    '{ROW_WORD, REG_ORIGIN_X,      16'h8ABC, 1'b0, '0},
    '{ROW_CFG,  REG_SPRITE_HEIGHT, 16'd2,    1'b0, '0},
    '{ROW_CFG,  REG_ORIGIN_Y,      16'd0,    1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'h6400, 1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'h0000, 1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'h8000, 1'b0, '0},
    '{ROW_CFG,  REG_SPRITE_WIDTH,  16'd8,    1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'h0300, 1'b0, '0},
    '{ROW_WORD, REG_ORIGIN_X,      16'h8155, 1'b1, '{16'h0000, 8'd3, 15'h0155, 1'b1}},
    '{ROW_WORD, REG_ORIGIN_X,      16'h8000, 1'b0, '0}
  };

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [WORD_W-1:0]     in_tdata = '0;      // [15:0] data_word
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // [15:0] segment_address, [23:16] segment_length, [38:24] fill_color, [39] zero
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  rle_sprite_run_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #10 clk = ~clk;

  logic [CFG_W-1:0] cf_origin_x = '0;
  logic [CFG_W-1:0] cf_origin_y = '0;
  logic [CFG_W-1:0] cf_width = WIDTH_RESET;
  logic [CFG_W-1:0] cf_height = HEIGHT_RESET;
  phase_t           cur_phase = PHASE_HEADER;
  logic [CNT_W-1:0] run_first = '0;
  logic [CNT_W-1:0] run_second = '0;
  logic [CNT_W-1:0] pos_col = '0;
  logic [CNT_W-1:0] pos_row = '0;

  segment_t    predicted [$];
  segment_t    pending_segments [$];
  int unsigned mismatches = 0;
  int unsigned segments_seen = 0;
  int unsigned words_sent = 0;
  int unsigned cycles = 0;
  int unsigned rx_hold = 0;
  bit          tx_gaps = 1'b1;
  bit          rx_gaps = 1'b1;

  task automatic fill_run(input int unsigned count, input logic [WORD_W-1:0] w);
    int unsigned wd, ht, col, row, room, seg, srow, scol, n;
    segment_t s;
    wd = (32'(cf_width) < MIN_WIDTH) ? MIN_WIDTH : 32'(cf_width);
    ht = 32'(cf_height);
    col = 32'(pos_col);
    row = 32'(pos_row);
    n = 0;
    while (count > 0 && row < ht) begin
      if (col >= wd) begin
        col = 0;
        row++;
        continue;
      end
      room = wd - col;
      seg = (count < room) ? count : room;
      if (w[OPAQUE_BIT] && n < MAX_SEGMENTS) begin
        srow = 32'(cf_origin_y) + ht - 1 - row;
        scol = 32'(cf_origin_x) + col;
        s.addr = ADDR_W'(srow * SCREEN_W + scol);
        s.len = CNT_W'(seg);
        s.color = w[COLOR_W-1:0];
        s.last = 1'b0;
        predicted.push_back(s);
        n++;
      end
      col += seg;
      count -= seg;
      if (col >= wd) begin
        col = 0;
        row++;
      end
    end
    if (n > 0) predicted[predicted.size()-1].last = 1'b1;
    pos_col = CNT_W'(col);
    pos_row = CNT_W'(row);
  endtask

  task automatic decode_word(input logic [WORD_W-1:0] w);
    predicted.delete();
    case (cur_phase)
      PHASE_FIRST: begin
        fill_run(32'(run_first), w);
        cur_phase = PHASE_SECOND;
      end
      PHASE_SECOND: begin
        fill_run(32'(run_second), w);
        cur_phase = PHASE_HEADER;
        if (pos_row >= cf_height) begin
          pos_col = '0;
          pos_row = '0;
        end
      end
      default: begin
        run_first = w[15:8];
        run_second = w[7:0];
        cur_phase = PHASE_FIRST;
      end
    endcase
  endtask

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("ERROR segment %0d %s: got 0x%0h, expected 0x%0h",
             segments_seen, what, got, want);
    mismatches++;
  endtask

  task automatic send_word(input logic [WORD_W-1:0] w, input bit typed, input segment_t want);
    int unsigned gap;
    gap = tx_gaps ? $urandom_range(0, 19) : 0;
    cfg_valid <= 1'b0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    do @(posedge clk); while (!in_tready);
    words_sent++;
    decode_word(w);
    if (typed) pending_segments.push_back(want);
    else foreach (predicted[i]) pending_segments.push_back(predicted[i]);
  endtask

  task automatic write_reg(input reg_idx_t idx, input logic [CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_ORIGIN_X:     cf_origin_x = v;
      REG_ORIGIN_Y:     cf_origin_y = v;
      REG_SPRITE_WIDTH: cf_width = v;
      default:          cf_height = v;
    endcase
  endtask

  // drop both request lines, drain, then give a word with no segments time to finish
  task automatic quiesce();
    in_tvalid <= 1'b0;
    cfg_valid <= 1'b0;
    while (pending_segments.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] draw_reg(input reg_idx_t idx);
    int unsigned pick;
    pick = $urandom_range(0, 5);
    case (idx)
      REG_ORIGIN_X:
        case (pick)
          0: return 8'd0;
          1: return 8'd239;
          2: return 8'd255;
          default: return CFG_W'($urandom_range(0, 239));
        endcase
      REG_ORIGIN_Y:
        case (pick)
          0: return 8'd0;
          1: return 8'd159;
          2: return 8'd255;
          default: return CFG_W'($urandom_range(0, 159));
        endcase
      REG_SPRITE_WIDTH:
        case (pick)
          0: return CFG_W'($urandom_range(0, 7));
          1: return 8'd8;
          2: return 8'd240;
          3: return 8'd255;
          default: return CFG_W'($urandom_range(8, 64));
        endcase
      default:
        case (pick)
          0: return 8'd0;
          1: return 8'd1;
          2: return 8'd160;
          3: return 8'd255;
          default: return CFG_W'($urandom_range(1, 8));
        endcase
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] draw_word(input bit header);
    logic [WORD_W-1:0] w;
    w = WORD_W'($urandom);
    if (header) begin
      case ($urandom_range(0, 3))
        0, 1: w = {8'($urandom_range(0, 15)), 8'($urandom_range(0, 15))};
        2: ;
        default: w = {($urandom_range(0, 1) ? 8'hFF : 8'h00), ($urandom_range(0, 1) ? 8'hFF : 8'h00)};
      endcase
    end else begin
      w[OPAQUE_BIT] = ($urandom_range(0, 9) < 7);
    end
    return w;
  endfunction

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    segment_t want;
    if (rst_n && out_tvalid && out_tready) begin
      segments_seen++;
      if (pending_segments.size() == 0) begin
        report_mismatch("segment with none pending", 64'(out_tdata[15:0]), '0);
      end else begin
        want = pending_segments.pop_front();
        if (out_tdata[15:0] !== want.addr)
          report_mismatch("address", 64'(out_tdata[15:0]), 64'(want.addr));
        if (out_tdata[23:16] !== want.len)
          report_mismatch("length", 64'(out_tdata[23:16]), 64'(want.len));
        if (out_tdata[38:24] !== want.color)
          report_mismatch("colour", 64'(out_tdata[38:24]), 64'(want.color));
        if (out_tlast !== want.last) report_mismatch("last", 64'(out_tlast), 64'(want.last));
      end
      if (out_tdata[39] !== 1'b0) report_mismatch("pad bit", 64'(out_tdata[39]), '0);
      rx_hold = rx_gaps ? $urandom_range(0, 19) : 0;
      if (rx_hold > 0) out_tready <= 1'b0;
    end else if (rx_hold > 0) begin
      rx_hold--;
      if (rx_hold == 0) out_tready <= 1'b1;
    end else if (rst_n && !out_tready) begin
      out_tready <= 1'b1;
    end
  end

  initial begin
    int unsigned groups;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (SCRIPT[i]) begin
      if (SCRIPT[i].kind == ROW_CFG) begin
        quiesce();
        write_reg(SCRIPT[i].idx, SCRIPT[i].value[CFG_W-1:0]);
      end else begin
        send_word(SCRIPT[i].value, SCRIPT[i].typed, SCRIPT[i].want);
      end
    end

    while (words_sent < SCRIPT_LEN + RANDOM_WORDS) begin
      quiesce();
      for (int r = 0; r < 4; r++)
        if ($urandom_range(0, 1)) write_reg(reg_idx_t'(r), draw_reg(reg_idx_t'(r)));
      tx_gaps = ($urandom_range(0, 3) != 0);
      rx_gaps = ($urandom_range(0, 3) != 0);
      // finish a group cut short before the register change
      while (cur_phase != PHASE_HEADER) send_word(draw_word(1'b0), 1'b0, '0);
      groups = $urandom_range(1, 8);
      for (int g = 0; g < groups; g++) begin
        send_word(draw_word(1'b1), 1'b0, '0);
        if ($urandom_range(0, 9) == 0) break;
        send_word(draw_word(1'b0), 1'b0, '0);
        if ($urandom_range(0, 9) == 0) break;
        send_word(draw_word(1'b0), 1'b0, '0);
      end
    end

    quiesce();
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/rsd_pkg.sv
rtl/rsd_ctrl.sv
rtl/rsd_datapath.sv
rtl/rle_sprite_run_decoder.sv
tb/rle_sprite_run_decoder_test.sv
